// File: design/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("positional list assertion failed");
`define PLE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list implication failed");
`define PLE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list next-cycle check failed");
`else
`define PLE_ASSERT(lbl, clk, rst, prop)
`define PLE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PLE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/ple_pkg.sv
// types and codes of the positional list engine
`default_nettype none
package ple_pkg;

   localparam int OpWidth     = 2;
   localparam int PosWidth    = 7;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 3;

   typedef enum logic [OpWidth-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_POS   = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

endpackage
`default_nettype wire

// File: design/positional_list_engine_unit.sv
// positional list engine: ordered list with insert, delete and search
//
//   channel   dir   fields
//   req_*     in    tuser: op | tdata: position, item_value
//   rsp_*     out   tuser: status | tdata: found_position, length_after | tlast
//
// one list memory with a registered read port, walked one entry a cycle,
// a search pausing while a match waits on a stalled result register
// reset clears the state, length and valid flags, the list memory needs no clearing
// a new transaction is taken once the previous one has loaded its last result
`default_nettype none
`include "assert_macros.svh"
module positional_list_engine_unit
   import ple_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // op
   input  wire logic [39:0] req_tdata,   // position[6:0], item_value[38:7], zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [2:0]       rsp_tuser,   // status
   output logic [15:0]      rsp_tdata,   // found_position[6:0], length_after[13:7], zero
   output logic             rsp_tlast
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_PUT,
      S_DEL_SHIFT,
      S_SRCH,
      S_RESP
   } state_type;

   state_type                 state_ff;
   logic [LW-1:0]             len_ff;
   logic [LW-1:0]             cnt_ff;
   logic [PosWidth-1:0]       pos_ff;
   logic [ValueWidth-1:0]     val_ff;
   logic [AW-1:0]             put_addr_ff;
   status_type                st_ff;
   logic                      pend_valid_ff;
   logic [AW-1:0]             pend_addr_ff;
   logic                      cmp_valid_ff;
   logic [LW-1:0]             cmp_idx_ff;
   logic                      held_ff;
   logic [PosWidth-1:0]       held_pos_ff;
   logic                      rsp_valid_ff;
   status_type                rsp_status_ff;
   logic [PosWidth-1:0]       rsp_found_ff;
   logic [PosWidth-1:0]       rsp_len_ff;
   logic                      rsp_last_ff;

   logic [ValueWidth-1:0]     mem [CAPACITY];
   logic [ValueWidth-1:0]     rd_data_ff;

   logic                      rd_en_in;
   logic [AW-1:0]             rd_addr_in;
   logic                      wr_en_in;
   logic [AW-1:0]             wr_addr_in;
   logic [ValueWidth-1:0]     wr_data_in;

   logic                      req_fire;
   logic                      can_emit;
   logic                      match;
   logic                      stall;
   logic                      finishing;
   logic [PosWidth-1:0]       req_pos;
   logic [ValueWidth-1:0]     req_val;
   logic [7:0]                len_ext;
   logic [7:0]                pos_ext;

   assign req_pos    = req_tdata[6:0];
   assign req_val    = req_tdata[38:7];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign can_emit   = !rsp_valid_ff || rsp_tready;
   assign match      = (rd_data_ff == val_ff);
   assign stall      = cmp_valid_ff && match && held_ff && !can_emit;
   assign finishing  = (cnt_ff == len_ff) && !cmp_valid_ff;
   assign len_ext    = 8'(len_ff);
   assign pos_ext    = 8'(pos_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_len_ff, rsp_found_ff};
   assign rsp_tlast  = rsp_last_ff;

   // read and write port control
   always_comb begin
      rd_en_in   = 1'b0;
      rd_addr_in = cnt_ff[AW-1:0];
      case (state_ff)
         S_INS_SHIFT: begin
            rd_en_in   = (8'(cnt_ff) >= pos_ext);
            rd_addr_in = AW'(cnt_ff - LW'(1));
         end
         S_DEL_SHIFT: begin
            rd_en_in   = ((8'(cnt_ff) + 8'd1) < len_ext);
            rd_addr_in = AW'(cnt_ff + LW'(1));
         end
         S_SRCH: begin
            rd_en_in   = !finishing && !stall && (cnt_ff < len_ff);
            rd_addr_in = cnt_ff[AW-1:0];
         end
         default: begin
            rd_en_in = 1'b0;
         end
      endcase
      if (pend_valid_ff) begin
         wr_en_in   = 1'b1;
         wr_addr_in = pend_addr_ff;
         wr_data_in = rd_data_ff;
      end else begin
         wr_en_in   = (state_ff == S_INS_PUT);
         wr_addr_in = put_addr_ff;
         wr_data_in = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         mem[wr_addr_in] <= wr_data_in;
      end
      if (rd_en_in) begin
         rd_data_ff <= mem[rd_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_ff        <= '0;
         pend_valid_ff <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         held_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= rd_en_in && (state_ff != S_SRCH);
         pend_addr_ff  <= cnt_ff[AW-1:0];
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  pos_ff       <= req_pos;
                  val_ff       <= req_val;
                  cmp_valid_ff <= 1'b0;
                  held_ff      <= 1'b0;
                  case (op_type'(req_tuser))
                     OP_INSERT: begin
                        if (len_ff == LW'(CAPACITY)) begin
                           st_ff    <= ST_FULL;
                           state_ff <= S_RESP;
                        end else if (len_ff == '0) begin
                           put_addr_ff <= '0;
                           state_ff    <= S_INS_PUT;
                        end else if (req_pos == '0 || 8'(req_pos) > len_ext + 8'd1) begin
                           st_ff    <= ST_BAD_POS;
                           state_ff <= S_RESP;
                        end else begin
                           cnt_ff      <= len_ff;
                           put_addr_ff <= AW'(req_pos - PosWidth'(1));
                           state_ff    <= S_INS_SHIFT;
                        end
                     end
                     OP_DELETE: begin
                        if (len_ff == '0) begin
                           st_ff    <= ST_EMPTY;
                           state_ff <= S_RESP;
                        end else if (req_pos == '0 || 8'(req_pos) > len_ext) begin
                           st_ff    <= ST_BAD_POS;
                           state_ff <= S_RESP;
                        end else begin
                           cnt_ff   <= LW'(req_pos - PosWidth'(1));
                           state_ff <= S_DEL_SHIFT;
                        end
                     end
                     OP_SEARCH: begin
                        cnt_ff   <= '0;
                        state_ff <= S_SRCH;
                     end
                     default: begin
                        st_ff    <= ST_OK;
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_INS_SHIFT: begin
               if (rd_en_in) begin
                  cnt_ff <= cnt_ff - LW'(1);
               end else begin
                  state_ff <= S_INS_PUT;
               end
            end
            S_INS_PUT: begin
               len_ff   <= len_ff + LW'(1);
               st_ff    <= ST_OK;
               state_ff <= S_RESP;
            end
            S_DEL_SHIFT: begin
               if (rd_en_in) begin
                  cnt_ff <= cnt_ff + LW'(1);
               end else begin
                  len_ff   <= len_ff - LW'(1);
                  st_ff    <= ST_OK;
                  state_ff <= S_RESP;
               end
            end
            S_SRCH: begin
               if (finishing) begin
                  if (can_emit) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= held_ff ? ST_OK : ST_NOT_FOUND;
                     rsp_found_ff  <= held_ff ? held_pos_ff : '0;
                     rsp_len_ff    <= PosWidth'(len_ff);
                     rsp_last_ff   <= 1'b1;
                     state_ff      <= S_IDLE;
                  end
               end else if (!stall) begin
                  if (cnt_ff < len_ff) begin
                     cnt_ff       <= cnt_ff + LW'(1);
                     cmp_valid_ff <= 1'b1;
                     cmp_idx_ff   <= cnt_ff;
                  end else begin
                     cmp_valid_ff <= 1'b0;
                  end
                  if (cmp_valid_ff && match) begin
                     if (held_ff) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= ST_OK;
                        rsp_found_ff  <= held_pos_ff;
                        rsp_len_ff    <= PosWidth'(len_ff);
                        rsp_last_ff   <= 1'b0;
                     end
                     held_ff     <= 1'b1;
                     held_pos_ff <= PosWidth'(cmp_idx_ff) + PosWidth'(1);
                  end
               end
            end
            S_RESP: begin
               if (can_emit) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= st_ff;
                  rsp_found_ff  <= '0;
                  rsp_len_ff    <= PosWidth'(len_ff);
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `PLE_ASSERT(a_len_bound, clock, reset, len_ff <= LW'(CAPACITY))
   `PLE_ASSERT_IMP(a_pend_in_list, clock, reset, pend_valid_ff, LW'(pend_addr_ff) <= len_ff)
   `PLE_ASSERT_IMP(a_held_in_list, clock, reset, held_ff && state_ff == S_SRCH, held_pos_ff <= PosWidth'(len_ff))
   `PLE_ASSERT_NXT(a_len_only_on_edit, clock, reset, state_ff != S_INS_PUT && state_ff != S_DEL_SHIFT, $stable(len_ff))

endmodule
`default_nettype wire
